FILE: rtl/core/ffba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int MAX_BLOCKS      = 64;
  localparam int AW              = $clog2(MAX_BLOCKS);
  localparam int CW              = $clog2(MAX_BLOCKS + 1);
  localparam int HEADER_BYTES    = 12;
  localparam int MIN_SPLIT_BYTES = 32;
  localparam int SPLIT_ALIGN     = 8;
  localparam int DEFAULT_ALIGN   = 4;

  localparam logic [31:0] ARENA_BASE_RST  = 32'hC060_0000;
  localparam logic [24:0] ARENA_BYTES_RST = 25'd4194304;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FAIL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_DOUBLE    = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    REG_ARENA_BASE  = 2'd0,
    REG_ARENA_BYTES = 2'd1,
    REG_MEM_PRESENT = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] start;
    logic [24:0] payload;
    logic        free;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [31:0] arena_base;
    logic [24:0] arena_bytes;
    logic        memory_present;
    logic        reinit;
  } cfg_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    logic [AW-1:0] raddr;
  } ram_req_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE,
    S_A_RD, S_A_EV, S_A_SPL, S_SH_RD, S_SH_WR, S_A_WNEW, S_A_WCUR,
    S_F_RD, S_F_EV,
    S_M_RD0, S_M_LD, S_M_RD, S_M_EV, S_D_RD, S_D_WR,
    S_ST0, S_ST, S_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/core/first_fit_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit arena allocator with split on allocate and merge on free.
// ----------------------------------------------------------------------------
// Usage: raise start with a request word on the in_ ports; it is taken when
// busy is low. in_opcode selects allocate or free. Exactly one result word
// follows, shown on the out_ ports for one cycle with out_valid high; the
// receiver cannot stall and must take it then. busy stays high from the
// accept until the cycle after out_valid.
// Sequence: the block table sits in one RAM with registered read data. The
// first-fit and free searches read and then test each entry visited, each
// table shift (split insert or merge delete) reads and then writes each moved
// entry, and a closing statistics pass reads every table entry.
// Reset and any write of registers 0..2 on the cfg_ port rebuild the table
// as one free block, or as an empty table while memory is marked absent;
// busy is high while that runs. cfg_ready is always high; writes are expected
// only while the block is idle.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_opcode,
  input  wire logic [31:0] in_alloc_size,
  input  wire logic [16:0] in_align_bytes,
  input  wire logic [31:0] in_target_address,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [31:0]      out_granted_address,
  output logic [24:0]      out_free_total,
  output logic [24:0]      out_largest_free,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import ffba_pkg::*;

  logic [31:0] arena_base_r;
  logic [24:0] arena_bytes_r;
  logic        mem_present_r;
  logic        reinit_r;
  cfg_t        cfg;
  ram_req_t    ram_req;
  logic [ENTRY_W-1:0] ram_rdata;
  logic        cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_base_r  <= ARENA_BASE_RST;
      arena_bytes_r <= ARENA_BYTES_RST;
      mem_present_r <= 1'b1;
      reinit_r      <= 1'b0;
    end else begin
      reinit_r <= 1'b0;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_ARENA_BASE: begin
            arena_base_r <= cfg_data;
            reinit_r     <= 1'b1;
          end
          REG_ARENA_BYTES: begin
            arena_bytes_r <= cfg_data[24:0];
            reinit_r      <= 1'b1;
          end
          REG_MEM_PRESENT: begin
            mem_present_r <= cfg_data[0];
            reinit_r      <= 1'b1;
          end
          REG_NONE: ;
          default: ;
        endcase
      end
    end
  end

  assign cfg = '{arena_base: arena_base_r, arena_bytes: arena_bytes_r,
                 memory_present: mem_present_r, reinit: reinit_r};

  ffba_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  ffba_core u_core (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_alloc_size       (in_alloc_size),
    .in_align_bytes      (in_align_bytes),
    .in_target_address   (in_target_address),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_granted_address (out_granted_address),
    .out_free_total      (out_free_total),
    .out_largest_free    (out_largest_free),
    .ram_req             (ram_req),
    .rd                  (entry_t'(ram_rdata))
  );

endmodule
`default_nettype wire

FILE: rtl/core/ffba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/ffba_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_core
// Sequencer for table init, first-fit search, split, free, merge and stats.
// ----------------------------------------------------------------------------
module ffba_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ffba_pkg::cfg_t    cfg,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_opcode,
  input  wire logic [31:0]       in_alloc_size,
  input  wire logic [16:0]       in_align_bytes,
  input  wire logic [31:0]       in_target_address,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [31:0]            out_granted_address,
  output logic [24:0]            out_free_total,
  output logic [24:0]            out_largest_free,
  output ffba_pkg::ram_req_t     ram_req,
  input  wire ffba_pkg::entry_t  rd
);
  import ffba_pkg::*;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] k_r, k_nxt;
  entry_t        cur_r, cur_nxt;
  opcode_t       op_r, op_nxt;
  logic [31:0]   size_r, size_nxt;
  logic [16:0]   a_r, a_nxt;
  logic [31:0]   addr_r, addr_nxt;
  status_t       status_r, status_nxt;
  logic [31:0]   granted_r, granted_nxt;
  logic [24:0]   total_r, total_nxt;
  logic [24:0]   largest_r, largest_nxt;
  logic          pv_r, pv_nxt;
  logic [32:0]   data_r, data_nxt;
  logic [33:0]   end_r, end_nxt;
  logic [33:0]   aligned_r, aligned_nxt;
  logic [35:0]   split_r, split_nxt;
  logic          dosplit_r, dosplit_nxt;

  logic [16:0]   a_m1;
  logic [32:0]   ev_data;
  logic [33:0]   ev_end, ev_aligned, ev_pad;
  logic          ev_fit, ev_hit, mg;
  logic [35:0]   sp_split;
  logic          sp_do;
  logic [32:0]   room, span;
  logic [24:0]   init_payload;
  logic          idx_lt, accept;
  logic [33:0]   cur_end;

  // a pending table rebuild holds off new words
  assign busy   = (state_r != S_IDLE) || cfg.reinit;
  assign accept = start && !busy;
  assign idx_lt = idx_r < cnt_r;

  // fit, hit and merge tests on the entry just read, split point, init payload
  always_comb begin
    a_m1       = a_r - 17'd1;
    ev_data    = {1'b0, rd.start} + 33'(HEADER_BYTES);
    ev_end     = {1'b0, ev_data} + 34'(rd.payload);
    ev_aligned = ({1'b0, ev_data} + 34'(a_m1)) & ~{17'b0, a_m1};
    ev_pad     = ev_aligned - {1'b0, ev_data};
    ev_fit     = rd.free && (ev_pad <= 34'(rd.payload)) &&
                 ((34'(rd.payload) - ev_pad) >= 34'(size_r));
    ev_hit     = ({1'b0, ev_data} <= 34'(addr_r)) && (34'(addr_r) < ev_end);
    sp_split   = ({2'b0, aligned_r} + 36'(size_r) + 36'(SPLIT_ALIGN - 1)) &
                 ~36'(SPLIT_ALIGN - 1);
    sp_do      = (cnt_r < CW'(MAX_BLOCKS)) &&
                 ({3'b0, end_r} >= ({1'b0, sp_split} +
                                    37'(HEADER_BYTES + MIN_SPLIT_BYTES)));
    cur_end    = {2'b0, cur_r.start} + 34'(HEADER_BYTES) + 34'(cur_r.payload);
    mg         = cur_r.free && rd.free && (cur_end == {2'b0, rd.start});
    room       = 33'h1_0000_0000 - {1'b0, cfg.arena_base};
    span       = (33'(cfg.arena_bytes) > room) ? room : 33'(cfg.arena_bytes);
    init_payload = (span > 33'(HEADER_BYTES)) ? 25'(span - 33'(HEADER_BYTES)) : 25'd0;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (opcode_t'(in_opcode) == OP_ALLOC) begin
            state_nxt = (in_alloc_size == 32'd0) ? S_ST0 : S_A_RD;
          end else begin
            state_nxt = (in_target_address == 32'd0) ? S_ST0 : S_F_RD;
          end
        end
      end
      S_A_RD:   state_nxt = idx_lt ? S_A_EV : S_ST0;
      S_A_EV:   state_nxt = ev_fit ? S_A_SPL : S_A_RD;
      S_A_SPL:  state_nxt = sp_do ? S_SH_RD : S_A_WCUR;
      S_SH_RD:  state_nxt = (k_r > idx_r + CW'(1)) ? S_SH_WR : S_A_WNEW;
      S_SH_WR:  state_nxt = S_SH_RD;
      S_A_WNEW: state_nxt = S_A_WCUR;
      S_A_WCUR: state_nxt = S_ST0;
      S_F_RD:   state_nxt = idx_lt ? S_F_EV : S_M_RD0;
      S_F_EV:   state_nxt = ev_hit ? S_M_RD0 : S_F_RD;
      S_M_RD0:  state_nxt = (cnt_r > CW'(1)) ? S_M_LD : S_ST0;
      S_M_LD:   state_nxt = S_M_RD;
      S_M_RD:   state_nxt = (idx_r + CW'(1) < cnt_r) ? S_M_EV : S_ST0;
      S_M_EV:   state_nxt = mg ? S_D_RD : S_M_RD;
      S_D_RD:   state_nxt = (k_r + CW'(1) < cnt_r) ? S_D_WR : S_M_RD;
      S_D_WR:   state_nxt = S_D_RD;
      S_ST0:    state_nxt = S_ST;
      S_ST:     state_nxt = (!idx_lt && !pv_r) ? S_DONE : S_ST;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_INIT;
    endcase
    if (cfg.reinit) begin
      state_nxt = S_INIT;
    end
  end

  // datapath and memory requests
  always_comb begin
    cnt_nxt = cnt_r;  idx_nxt = idx_r;  k_nxt = k_r;  cur_nxt = cur_r;
    op_nxt = op_r;  size_nxt = size_r;  a_nxt = a_r;  addr_nxt = addr_r;
    status_nxt = status_r;  granted_nxt = granted_r;
    total_nxt = total_r;  largest_nxt = largest_r;  pv_nxt = pv_r;
    data_nxt = data_r;  end_nxt = end_r;  aligned_nxt = aligned_r;
    split_nxt = split_r;  dosplit_nxt = dosplit_r;
    ram_req.we    = 1'b0;
    ram_req.waddr = idx_r[AW-1:0];
    ram_req.wdata = rd;
    ram_req.raddr = idx_r[AW-1:0];
    unique case (state_r)
      S_INIT: begin
        ram_req.we    = cfg.memory_present;
        ram_req.waddr = '0;
        ram_req.wdata = '{start: cfg.arena_base, payload: init_payload, free: 1'b1};
        cnt_nxt       = cfg.memory_present ? CW'(1) : CW'(0);
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt      = opcode_t'(in_opcode);
          size_nxt    = in_alloc_size;
          a_nxt       = (in_align_bytes == 17'd0) ? 17'(DEFAULT_ALIGN) : in_align_bytes;
          addr_nxt    = in_target_address;
          idx_nxt     = '0;
          granted_nxt = '0;
          if (opcode_t'(in_opcode) == OP_ALLOC) begin
            status_nxt = (in_alloc_size == 32'd0) ? ST_FAIL : ST_OK;
          end else begin
            status_nxt = (in_target_address == 32'd0) ? ST_OK : ST_NOT_FOUND;
          end
        end
      end
      S_A_RD: begin
        if (!idx_lt) begin
          status_nxt = ST_FAIL;
        end
      end
      S_A_EV: begin
        if (ev_fit) begin
          cur_nxt     = rd;
          data_nxt    = ev_data;
          end_nxt     = ev_end;
          aligned_nxt = ev_aligned;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_A_SPL: begin
        split_nxt   = sp_split;
        dosplit_nxt = sp_do;
        k_nxt       = cnt_r;
      end
      S_SH_RD: ram_req.raddr = AW'(k_r - CW'(1));
      S_SH_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = k_r[AW-1:0];
        k_nxt         = k_r - CW'(1);
      end
      S_A_WNEW: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = AW'(idx_r + CW'(1));
        ram_req.wdata = '{start: split_r[31:0],
                          payload: 25'({2'b0, end_r} - split_r - 36'(HEADER_BYTES)),
                          free: 1'b1};
      end
      S_A_WCUR: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = '{start: cur_r.start,
                          payload: dosplit_r ? 25'(split_r - {3'b0, data_r}) : cur_r.payload,
                          free: 1'b0};
        if (dosplit_r) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        granted_nxt = aligned_r[31:0];
        status_nxt  = ST_OK;
      end
      S_F_EV: begin
        if (ev_hit) begin
          status_nxt    = rd.free ? ST_DOUBLE : ST_OK;
          ram_req.we    = 1'b1;
          ram_req.wdata = '{start: rd.start, payload: rd.payload, free: 1'b1};
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_M_RD0: begin
        idx_nxt       = '0;
        ram_req.raddr = '0;
      end
      S_M_LD: cur_nxt = rd;
      S_M_RD: ram_req.raddr = AW'(idx_r + CW'(1));
      S_M_EV: begin
        if (mg) begin
          // absorb the next block and its header
          cur_nxt.payload = cur_r.payload + 25'(HEADER_BYTES) + rd.payload;
          ram_req.we      = 1'b1;
          ram_req.wdata   = '{start: cur_r.start,
                              payload: cur_r.payload + 25'(HEADER_BYTES) + rd.payload,
                              free: 1'b1};
          k_nxt           = idx_r + CW'(1);
        end else begin
          cur_nxt = rd;
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_D_RD: begin
        ram_req.raddr = AW'(k_r + CW'(1));
        if (!(k_r + CW'(1) < cnt_r)) begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      S_D_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = k_r[AW-1:0];
        k_nxt         = k_r + CW'(1);
      end
      S_ST0: begin
        idx_nxt     = '0;
        total_nxt   = '0;
        largest_nxt = '0;
        pv_nxt      = 1'b0;
      end
      S_ST: begin
        // streaming read, data lands in the cycle after the address
        pv_nxt = idx_lt;
        if (idx_lt) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (pv_r && rd.free) begin
          total_nxt = total_r + rd.payload;
          if (rd.payload > largest_r) begin
            largest_nxt = rd.payload;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= '0;
      idx_r   <= '0;
      k_r     <= '0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      k_r     <= k_nxt;
      pv_r    <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    op_r      <= op_nxt;
    size_r    <= size_nxt;
    a_r       <= a_nxt;
    addr_r    <= addr_nxt;
    status_r  <= status_nxt;
    granted_r <= granted_nxt;
    total_r   <= total_nxt;
    largest_r <= largest_nxt;
    data_r    <= data_nxt;
    end_r     <= end_nxt;
    aligned_r <= aligned_nxt;
    split_r   <= split_nxt;
    dosplit_r <= dosplit_nxt;
  end

  assign out_valid           = (state_r == S_DONE);
  assign out_status          = status_r;
  assign out_granted_address = (op_r == OP_ALLOC) ? granted_r : 32'd0;
  assign out_free_total      = total_r;
  assign out_largest_free    = largest_r;

endmodule
`default_nettype wire

FILE: rtl/core/ffba_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks of the allocator, attached by bind.
// ----------------------------------------------------------------------------
module ffba_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [1:0]  out_status,
  input wire logic [31:0] out_granted_address,
  input wire logic [24:0] out_free_total,
  input wire logic [24:0] out_largest_free
);
  import ffba_pkg::*;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised after accept");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result word while idle");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_granted_address == 32'd0))
    else $error("address granted on failed request");

  a_largest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_largest_free <= out_free_total))
    else $error("largest free block exceeds free total");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_status          (out_status),
  .out_granted_address (out_granted_address),
  .out_free_total      (out_free_total),
  .out_largest_free    (out_largest_free)
);
`default_nettype wire

FILE: dv/tb_first_fit_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator
// Checks the allocator against a mirror of its block table kept in the bench.
// Every accepted request is applied to the mirror. Each result word must
// match the oldest pending word in status, grant and free statistics.
// Directed requests cover the edge cases, then random traffic runs over
// several arena settings.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator;
  import ffba_pkg::*;

  typedef struct {
    status_t     status;
    logic [31:0] granted;
    logic [24:0] total;
    logic [24:0] largest;
  } result_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_opcode = OP_ALLOC;
  logic [31:0] in_alloc_size = '0;
  logic [16:0] in_align_bytes = '0;
  logic [31:0] in_target_address = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_granted_address;
  logic [24:0] out_free_total;
  logic [24:0] out_largest_free;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_ARENA_BASE;
  logic [31:0] cfg_data = '0;

  // mirror of the block table and registers
  logic [31:0] tbl_start [MAX_BLOCKS];
  logic [24:0] tbl_size [MAX_BLOCKS];
  logic        tbl_free [MAX_BLOCKS];
  int          tbl_count;
  logic [31:0] base_reg = ARENA_BASE_RST;
  logic [24:0] bytes_reg = ARENA_BYTES_RST;
  logic        mem_reg = 1'b1;

  result_word_t pending_results[$];
  logic [31:0]  grant_pool[$];
  int           error_count = 0;
  bit           no_idle = 0;

  always #2 clk = ~clk;

  first_fit_block_allocator u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_alloc_size(in_alloc_size),
    .in_align_bytes(in_align_bytes), .in_target_address(in_target_address),
    .out_valid(out_valid), .out_status(out_status),
    .out_granted_address(out_granted_address), .out_free_total(out_free_total),
    .out_largest_free(out_largest_free), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint unsigned round_mask(longint unsigned v, longint unsigned a);
    return (v + a - 1) & ~(a - 1);
  endfunction

  function automatic void arena_rebuild();
    longint unsigned span, room;
    span = bytes_reg;
    room = 64'h1_0000_0000 - base_reg;
    if (span > room) span = room;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      tbl_start[i] = '0;
      tbl_size[i] = '0;
      tbl_free[i] = 1'b0;
    end
    if (!mem_reg) begin
      tbl_count = 0;
      return;
    end
    tbl_start[0] = base_reg;
    tbl_size[0] = (span > HEADER_BYTES) ? 25'(span - HEADER_BYTES) : '0;
    tbl_free[0] = 1'b1;
    tbl_count = 1;
  endfunction

  function automatic status_t arena_alloc(logic [31:0] size, logic [16:0] align,
                                          output logic [31:0] granted);
    longint unsigned a, data, endp, aligned, pad, split;
    granted = '0;
    a = (align != 0) ? longint'(align) : DEFAULT_ALIGN;
    if (size == 0) return ST_FAIL;
    for (int i = 0; i < tbl_count; i++) begin
      if (!tbl_free[i]) continue;
      data = longint'(tbl_start[i]) + HEADER_BYTES;
      endp = data + tbl_size[i];
      aligned = round_mask(data, a);
      pad = aligned - data;
      if (tbl_size[i] < pad || tbl_size[i] - pad < size) continue;
      split = round_mask(aligned + size, SPLIT_ALIGN);
      if (tbl_count < MAX_BLOCKS && endp >= split + HEADER_BYTES + MIN_SPLIT_BYTES) begin
        for (int k = tbl_count; k > i + 1; k--) begin
          tbl_start[k] = tbl_start[k-1];
          tbl_size[k] = tbl_size[k-1];
          tbl_free[k] = tbl_free[k-1];
        end
        tbl_start[i+1] = split[31:0];
        tbl_size[i+1] = 25'(endp - split - HEADER_BYTES);
        tbl_free[i+1] = 1'b1;
        tbl_size[i] = 25'(split - data);
        tbl_count++;
      end
      tbl_free[i] = 1'b0;
      granted = aligned[31:0];
      return ST_OK;
    end
    return ST_FAIL;
  endfunction

  function automatic status_t arena_free(logic [31:0] addr);
    status_t st;
    longint unsigned data, endp;
    int i;
    st = ST_NOT_FOUND;
    if (addr == 0) return ST_OK;
    for (i = 0; i < tbl_count; i++) begin
      data = longint'(tbl_start[i]) + HEADER_BYTES;
      if (data <= addr && longint'(addr) < data + tbl_size[i]) begin
        st = tbl_free[i] ? ST_DOUBLE : ST_OK;
        tbl_free[i] = 1'b1;
        break;
      end
    end
    // merge pass over neighbors
    i = 0;
    while (i + 1 < tbl_count) begin
      endp = longint'(tbl_start[i]) + HEADER_BYTES + tbl_size[i];
      if (tbl_free[i] && tbl_free[i+1] && endp == longint'(tbl_start[i+1])) begin
        tbl_size[i] = tbl_size[i] + HEADER_BYTES + tbl_size[i+1];
        for (int k = i + 1; k + 1 < tbl_count; k++) begin
          tbl_start[k] = tbl_start[k+1];
          tbl_size[k] = tbl_size[k+1];
          tbl_free[k] = tbl_free[k+1];
        end
        tbl_count--;
      end else begin
        i++;
      end
    end
    return st;
  endfunction

  function automatic result_word_t arena_request(opcode_t op, logic [31:0] size,
                                                 logic [16:0] align, logic [31:0] addr);
    result_word_t r;
    longint unsigned sum;
    r.granted = '0;
    r.largest = '0;
    sum = 0;
    if (op == OP_ALLOC) r.status = arena_alloc(size, align, r.granted);
    else r.status = arena_free(addr);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_free[i]) begin
        sum += tbl_size[i];
        if (tbl_size[i] > r.largest) r.largest = tbl_size[i];
      end
    end
    r.total = sum[24:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got 0x%08h want 0x%08h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // one request word; called right after a rising edge
  task automatic send_request(opcode_t op, logic [31:0] size, logic [16:0] align,
                              logic [31:0] addr);
    result_word_t r;
    int g;
    start <= 1'b1;
    in_opcode <= op;
    in_alloc_size <= size;
    in_align_bytes <= align;
    in_target_address <= addr;
    do @(posedge clk); while (busy);
    r = arena_request(op, size, align, addr);
    pending_results.push_back(r);
    if (op == OP_ALLOC && r.status == ST_OK) begin
      grant_pool.push_back(r.granted);
      if (grant_pool.size() > 96) void'(grant_pool.pop_front());
    end
    g = pick_gap();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ARENA_BASE:  base_reg = value;
      REG_ARENA_BYTES: bytes_reg = value[24:0];
      REG_MEM_PRESENT: mem_reg = value[0];
      default: ;
    endcase
    if (idx != REG_NONE) arena_rebuild();
    grant_pool.delete();
  endtask

  task automatic set_arena(logic [31:0] b, logic [24:0] n, logic m);
    write_reg(REG_ARENA_BASE, b);
    write_reg(REG_ARENA_BYTES, {7'd0, n});
    write_reg(REG_MEM_PRESENT, {31'd0, m});
  endtask

  always @(posedge clk) begin
    result_word_t w;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        error_count++;
      end else begin
        w = pending_results.pop_front();
        if (out_status != w.status) report_mismatch("status", out_status, w.status);
        if (out_granted_address != w.granted)
          report_mismatch("granted_address", out_granted_address, w.granted);
        if (out_free_total != w.total) report_mismatch("free_total", out_free_total, w.total);
        if (out_largest_free != w.largest)
          report_mismatch("largest_free", out_largest_free, w.largest);
      end
    end
  end

  task automatic test_directed_edges();
    logic [31:0] a0;
    send_request(OP_ALLOC, 32'd0, 17'd0, '0);
    send_request(OP_ALLOC, 32'hFFFF_FFFF, 17'd0, '0);
    send_request(OP_ALLOC, 32'd100, 17'd0, '0);
    a0 = grant_pool[$];
    send_request(OP_ALLOC, 32'd1, 17'd65536, '0);
    send_request(OP_ALLOC, 32'd33, 17'd3, '0);
    send_request(OP_ALLOC, 32'd7, 17'h1FFFF & 17'd65535, '0);
    send_request(OP_FREE, '0, '0, 32'd0);
    send_request(OP_FREE, '0, '0, 32'd1);
    send_request(OP_FREE, '0, '0, 32'hFFFF_FFFF);
    send_request(OP_FREE, '0, '0, a0 + 32'd5);
    send_request(OP_FREE, '0, '0, a0);
    // request near the arena size; it exceeds the largest free block and fails
    send_request(OP_ALLOC, 32'd4194000, 17'd0, '0);
    drain();
  endtask

  task automatic test_config_extremes();
    set_arena(32'h0000_1000, 25'd256, 1'b0);
    send_request(OP_ALLOC, 32'd8, 17'd0, '0);
    send_request(OP_FREE, '0, '0, 32'h0000_1010);
    send_request(OP_FREE, '0, '0, 32'd0);
    // arena clipped at the top of the address space
    set_arena(32'hFFFF_F000, 25'd16777216, 1'b1);
    send_request(OP_ALLOC, 32'd64, 17'd16, '0);
    send_request(OP_ALLOC, 32'd8192, 17'd0, '0);
    // span below one header leaves a zero payload
    set_arena(32'hFFFF_FFF8, 25'd64, 1'b1);
    send_request(OP_ALLOC, 32'd1, 17'd0, '0);
    set_arena(32'hFFFF_FFFF, 25'd64, 1'b1);
    send_request(OP_FREE, '0, '0, 32'hFFFF_FFFF);
    set_arena(32'h0000_0000, 25'd64, 1'b1);
    send_request(OP_ALLOC, 32'd52, 17'd0, '0);
    send_request(OP_ALLOC, 32'd1, 17'd0, '0);
    write_reg(REG_NONE, 32'hDEAD_BEEF);
    send_request(OP_FREE, '0, '0, 32'd12);
    drain();
  endtask

  task automatic random_request(logic [24:0] span);
    int p;
    logic [31:0] sz, tgt;
    logic [16:0] al;
    p = $urandom_range(0, 99);
    if (p < 55 || grant_pool.size() == 0) begin
      p = $urandom_range(0, 99);
      if (p < 80) sz = $urandom_range(1, 200);
      else if (p < 92) sz = $urandom_range(1, span);
      else if (p < 97) sz = $urandom;
      else sz = 0;
      case ($urandom_range(0, 7))
        0: al = 17'd0;
        1: al = 17'd4;
        2: al = 17'd8;
        3: al = 17'd1 << $urandom_range(0, 16);
        4: al = 17'($urandom_range(1, 7));
        5: al = 17'($urandom_range(0, 65536));
        default: al = 17'd0;
      endcase
      send_request(OP_ALLOC, sz, al, $urandom);
    end else begin
      p = $urandom_range(0, 99);
      if (p < 75) tgt = grant_pool[$urandom_range(0, grant_pool.size() - 1)];
      else if (p < 85) tgt = grant_pool[$urandom_range(0, grant_pool.size() - 1)]
                             + $urandom_range(1, 64);
      else if (p < 92) tgt = 0;
      else tgt = $urandom;
      send_request(OP_FREE, $urandom, 17'($urandom), tgt);
    end
  endtask

  task automatic test_random_traffic();
    logic [31:0] bases [7] = '{ARENA_BASE_RST, 32'h2000_0000, 32'h0000_1000,
                               32'hFFFF_F000, 32'h8000_0000, 32'h4000_0000, 32'h1234_5678};
    logic [24:0] sizes [7] = '{ARENA_BYTES_RST, 25'd2048, 25'd16777216, 25'd100000,
                               25'd64, 25'd600, 25'd4096};
    int counts [7] = '{200, 200, 150, 150, 50, 200, 70};
    for (int ph = 0; ph < 7; ph++) begin
      if (ph != 0) set_arena(bases[ph], sizes[ph], ph != 6);
      for (int n = 0; n < counts[ph]; n++) begin
        if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if (n % 97 == 50) drain();
        random_request(sizes[ph]);
      end
      no_idle = 0;
    end
    drain();
  endtask

  initial begin
    arena_rebuild();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_config_extremes();
    set_arena(ARENA_BASE_RST, ARENA_BYTES_RST, 1'b1);
    test_random_traffic();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
